// ===== hw/rtl/alc_pkg.sv =====
// Shared types and constants for the audio loss concealment core.
// Holds the request/response beat structs, operation codes and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package alc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SIZE_W   = 9;
   localparam int COUNT_W  = 32;
   localparam int STEP_W   = 17;

   // Q1.16 unity weight
   localparam logic [STEP_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic [1:0] FUNC_GOOD    = 2'd0;
   localparam logic [1:0] FUNC_HINT    = 2'd1;
   localparam logic [1:0] FUNC_CONCEAL = 2'd2;
   // no effect at all: no store write, no beat, position held
   localparam logic [1:0] FUNC_SKIP    = 2'd3;

   localparam logic [1:0] STRAT_SILENCE = 2'd0;
   localparam logic [1:0] STRAT_REPEAT  = 2'd1;
   localparam logic [1:0] STRAT_INTERP  = 2'd2;

   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_SILENCE = 2'd1;
   localparam logic [1:0] MODE_REPEAT  = 2'd2;
   localparam logic [1:0] MODE_INTERP  = 2'd3;

   localparam logic CSR_STRATEGY   = 1'b0;
   localparam logic CSR_MAX_STREAK = 1'b1;
   localparam int   CSR_DATA_W     = 4;

   typedef struct packed {
      logic [1:0]                 func;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       frame_end;
      logic [SIZE_W-1:0]          out_size;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       produced;
      logic                       out_last;
      logic [SIZE_W-1:0]          written_count;
      logic [COUNT_W-1:0]         total_concealed;
   } rsp_type;

endpackage

// ===== hw/rtl/alc_div.sv =====
// Radix-2 restoring divider for the crossfade weight step.
// Computes (65536 + d/2) / d, one quotient bit per cycle. Uses alc_pkg.
`timescale 1ns / 1ps

module alc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [alc_pkg::SIZE_W-1:0]  divisor,
   output logic [alc_pkg::STEP_W-1:0]  quotient,
   output logic                        done
);

   localparam int CNT_W = $clog2(alc_pkg::STEP_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [alc_pkg::SIZE_W-1:0]  dvs_ff, dvs_in;
   logic [alc_pkg::SIZE_W-1:0]  rem_ff, rem_in;
   logic [alc_pkg::STEP_W-1:0]  quo_ff, quo_in;
   logic [alc_pkg::SIZE_W:0]    trial;
   logic                        take;

   assign trial = {rem_ff, quo_ff[alc_pkg::STEP_W-1]};
   assign take  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(alc_pkg::STEP_W);
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = alc_pkg::ONE_Q16 + alc_pkg::STEP_W'(divisor >> 1);
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = take ? alc_pkg::SIZE_W'(trial - {1'b0, dvs_ff})
                       : alc_pkg::SIZE_W'(trial);
         quo_in = {quo_ff[alc_pkg::STEP_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== hw/rtl/audio_loss_concealment_core.sv =====
// Audio loss concealment core: frame stores, strategy control, crossfade datapath.
// Depends on alc_pkg and alc_div.
//
//   channel   ports                          beat contents
//   request   req_valid/req_ready/req_data    good, hint or conceal item (req_type)
//   response  rsp_valid/rsp_ready/rsp_data    one beat per conceal request (rsp_type)
//   config    csr_we/csr_index/csr_wdata      strategy, max_streak; no read-back
//
// Good and hint samples write the frame stores directly. A conceal request steps
// through store read, weight multiply, blend multiply and output load. The first
// request of an interpolated frame spanning two or more samples also waits for the
// bit-serial weight-step divider. Reset needs no clearing pass: reads past the
// loaded length return zero. A conceal request waits in its output-load step while
// the output register holds an unaccepted beat; no request is taken until it ends.
`timescale 1ns / 1ps

module audio_loss_concealment_core #(
   parameter int FRAME_DEPTH = 480
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  alc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output alc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [alc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int PW    = alc_pkg::SIZE_W;
   localparam int LW    = alc_pkg::SIZE_W + 1;
   localparam int SW    = alc_pkg::SAMPLE_W;
   localparam int KW    = alc_pkg::STEP_W;
   localparam int WGT_W = PW + KW;
   localparam int MIX_W = (SW + 1) + (KW + 1);
   localparam int SUM_W = MIX_W + 1;
   localparam logic [12:0]   DEPTH_C = 13'(FRAME_DEPTH);
   localparam logic [PW-1:0] POS_MAX = '1;
   localparam logic signed [SUM_W-17:0] BLEND_HI = (SUM_W-16)'(32'sh7FFF);
   localparam logic signed [SUM_W-17:0] BLEND_LO = -(SUM_W-16)'(32'sh8000);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_WGT  = 3'd2;
   localparam logic [2:0] S_MIX  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   // configuration
   logic [1:0] strategy_ff;
   logic [3:0] max_streak_ff;

   // control state
   logic [2:0]                 state_ff, state_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic [1:0]                 mode_ff, mode_in;
   logic [LW-1:0]              last_len_ff, last_len_in;
   logic [LW-1:0]              hint_len_ff, hint_len_in;
   logic                       have_last_ff, have_last_in;
   logic                       have_hint_ff, have_hint_in;
   logic [3:0]                 streak_ff, streak_in;
   logic [alc_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [KW-1:0]              step_ff, step_in;
   logic                       rsp_valid_ff;
   alc_pkg::rsp_type           rsp_data_ff;

   // per-request payload
   logic [PW-1:0]        op_pos_ff, op_pos_in;
   logic [1:0]           op_mode_ff, op_mode_in;
   logic                 op_prod_ff, op_prod_in;
   logic                 op_last_ff, op_last_in;
   logic [PW-1:0]        op_wcnt_ff, op_wcnt_in;
   logic                 l_ok_ff, l_ok_in;
   logic                 h_ok_ff, h_ok_in;
   logic [WGT_W-1:0]     wgt_ff, wgt_in;
   logic signed [MIX_W-1:0] mix_ff, mix_in;

   // frame stores
   logic signed [SW-1:0] last_mem [FRAME_DEPTH];
   logic signed [SW-1:0] hint_mem [FRAME_DEPTH];
   logic signed [SW-1:0] last_q_ff, hint_q_ff;
   logic [AW+PW-1:0]     pos_wide;
   logic [AW-1:0]        mem_addr;
   logic                 last_we, hint_we, mem_re;

   // combinational helpers
   logic                 req_fire, is_start, in_depth, cap_hit, need_div;
   logic [PW-1:0]        span_n, written_now;
   logic [LW-1:0]        load_len;
   logic [1:0]           mode_sel, mode_now;
   logic                 prod_now;
   logic                 div_start, div_done;
   logic [KW-1:0]        div_q;
   logic                 rsp_load;
   logic signed [SW-1:0] l_val, h_val, blend_val, out_val;
   logic signed [SW:0]   diff;
   logic [KW-1:0]        wgt_sat;
   logic signed [SUM_W-1:0] blend_sum;
   logic signed [SUM_W-17:0] blend_r;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign is_start  = (pos_ff == '0);
   assign in_depth  = ({4'b0, pos_ff} < DEPTH_C);
   assign pos_wide  = (AW + PW)'(pos_ff);
   assign mem_addr  = pos_wide[AW-1:0];
   assign cap_hit   = (streak_ff >= max_streak_ff);

   assign span_n   = ({4'b0, req_data.out_size} < DEPTH_C) ? req_data.out_size
                                                            : PW'(FRAME_DEPTH);
   assign load_len = ({4'b0, pos_ff} + 13'd1 < DEPTH_C) ? LW'({1'b0, pos_ff} + 1'b1)
                                                        : LW'(FRAME_DEPTH);

   always_comb begin
      mode_sel = alc_pkg::MODE_NONE;
      if (!cap_hit) begin
         case (strategy_ff)
            alc_pkg::STRAT_SILENCE: mode_sel = alc_pkg::MODE_SILENCE;
            alc_pkg::STRAT_REPEAT:  mode_sel = have_last_ff ? alc_pkg::MODE_REPEAT
                                                            : alc_pkg::MODE_NONE;
            alc_pkg::STRAT_INTERP: begin
               if (have_last_ff) begin
                  mode_sel = have_hint_ff ? alc_pkg::MODE_INTERP : alc_pkg::MODE_REPEAT;
               end
            end
            default: mode_sel = alc_pkg::MODE_NONE;
         endcase
      end
   end

   assign mode_now = is_start ? mode_sel : mode_ff;
   assign need_div = is_start && (mode_sel == alc_pkg::MODE_INTERP) && (span_n >= PW'(2));

   always_comb begin
      prod_now    = 1'b0;
      written_now = '0;
      case (mode_now)
         alc_pkg::MODE_SILENCE: begin
            prod_now    = (pos_ff < req_data.out_size);
            written_now = req_data.out_size;
         end
         alc_pkg::MODE_REPEAT, alc_pkg::MODE_INTERP: begin
            prod_now    = (pos_ff < span_n);
            written_now = span_n;
         end
         default: begin
            prod_now    = 1'b0;
            written_now = '0;
         end
      endcase
   end

   // blend datapath
   assign l_val   = l_ok_ff ? last_q_ff : '0;
   assign h_val   = h_ok_ff ? hint_q_ff : '0;
   assign diff    = {h_val[SW-1], h_val} - {l_val[SW-1], l_val};
   assign wgt_sat = (wgt_ff > WGT_W'(alc_pkg::ONE_Q16)) ? alc_pkg::ONE_Q16 : wgt_ff[KW-1:0];
   assign blend_sum = {{(SUM_W-SW-16){l_val[SW-1]}}, l_val, 16'h0000}
                    + {mix_ff[MIX_W-1], mix_ff}
                    + SUM_W'(32'h8000);
   assign blend_r = blend_sum[SUM_W-1:16];

   always_comb begin
      if (blend_r > BLEND_HI) begin
         blend_val = {1'b0, {(SW-1){1'b1}}};
      end else if (blend_r < BLEND_LO) begin
         blend_val = {1'b1, {(SW-1){1'b0}}};
      end else begin
         blend_val = blend_r[SW-1:0];
      end
   end

   always_comb begin
      out_val = '0;
      if (op_prod_ff) begin
         case (op_mode_ff)
            alc_pkg::MODE_REPEAT: out_val = l_val;
            alc_pkg::MODE_INTERP: out_val = blend_val;
            default:              out_val = '0;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      mode_in      = mode_ff;
      last_len_in  = last_len_ff;
      hint_len_in  = hint_len_ff;
      have_last_in = have_last_ff;
      have_hint_in = have_hint_ff;
      streak_in    = streak_ff;
      total_in     = total_ff;
      step_in      = step_ff;
      op_pos_in    = op_pos_ff;
      op_mode_in   = op_mode_ff;
      op_prod_in   = op_prod_ff;
      op_last_in   = op_last_ff;
      op_wcnt_in   = op_wcnt_ff;
      l_ok_in      = l_ok_ff;
      h_ok_in      = h_ok_ff;
      wgt_in       = wgt_ff;
      mix_in       = mix_ff;
      last_we      = 1'b0;
      hint_we      = 1'b0;
      mem_re       = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.func) inside
                  alc_pkg::FUNC_GOOD, alc_pkg::FUNC_HINT: begin
                     if (is_start) mode_in = alc_pkg::MODE_NONE;
                     // drop samples past the store depth
                     last_we = in_depth && (req_data.func == alc_pkg::FUNC_GOOD);
                     hint_we = in_depth && (req_data.func == alc_pkg::FUNC_HINT);
                     if (req_data.frame_end) begin
                        if (req_data.func == alc_pkg::FUNC_GOOD) begin
                           last_len_in  = load_len;
                           have_last_in = 1'b1;
                           streak_in    = '0;
                        end else begin
                           hint_len_in  = load_len;
                           have_hint_in = 1'b1;
                        end
                     end
                  end
                  alc_pkg::FUNC_CONCEAL: begin
                     mem_re = 1'b1;
                     if (is_start) begin
                        mode_in = mode_sel;
                        step_in = '0;
                        if (!cap_hit) have_hint_in = 1'b0;
                     end
                     op_pos_in  = pos_ff;
                     op_mode_in = mode_now;
                     op_prod_in = prod_now;
                     op_last_in = req_data.frame_end;
                     op_wcnt_in = req_data.frame_end ? written_now : '0;
                     l_ok_in    = ({1'b0, pos_ff} < last_len_ff);
                     h_ok_in    = ({1'b0, pos_ff} < hint_len_ff);
                     if (req_data.frame_end && (written_now != '0)) begin
                        if (streak_ff != 4'hF) streak_in = streak_ff + 1'b1;
                        total_in = total_ff + 1'b1;
                     end
                     div_start = need_div;
                     state_in  = need_div ? S_DIV : S_WGT;
                  end
                  default: begin
                  end
               endcase
               if (req_data.func != alc_pkg::FUNC_SKIP) begin
                  if (req_data.frame_end) begin
                     pos_in = '0;
                  end else if (pos_ff != POS_MAX) begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               step_in  = div_q;
               state_in = S_WGT;
            end
         end
         S_WGT: begin
            wgt_in   = WGT_W'(op_pos_ff) * WGT_W'(step_ff);
            state_in = S_MIX;
         end
         S_MIX: begin
            mix_in   = diff * $signed({1'b0, wgt_sat});
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   alc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (span_n - 1'b1),
      .quotient (div_q),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff   <= alc_pkg::STRAT_REPEAT;
         max_streak_ff <= 4'd5;
      end else if (csr_we) begin
         unique case (csr_index)
            alc_pkg::CSR_STRATEGY:   strategy_ff   <= csr_wdata[1:0];
            alc_pkg::CSR_MAX_STREAK: max_streak_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         mode_ff      <= alc_pkg::MODE_NONE;
         last_len_ff  <= '0;
         hint_len_ff  <= '0;
         have_last_ff <= 1'b0;
         have_hint_ff <= 1'b0;
         streak_ff    <= '0;
         total_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         mode_ff      <= mode_in;
         last_len_ff  <= last_len_in;
         hint_len_ff  <= hint_len_in;
         have_last_ff <= have_last_in;
         have_hint_ff <= have_hint_in;
         streak_ff    <= streak_in;
         total_ff     <= total_in;
         step_ff      <= step_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_pos_ff  <= op_pos_in;
      op_mode_ff <= op_mode_in;
      op_prod_ff <= op_prod_in;
      op_last_ff <= op_last_in;
      op_wcnt_ff <= op_wcnt_in;
      l_ok_ff    <= l_ok_in;
      h_ok_ff    <= h_ok_in;
      wgt_ff     <= wgt_in;
      mix_ff     <= mix_in;
      if (rsp_load) begin
         rsp_data_ff.out_sample      <= out_val;
         rsp_data_ff.produced        <= op_prod_ff;
         rsp_data_ff.out_last        <= op_last_ff;
         rsp_data_ff.written_count   <= op_wcnt_ff;
         rsp_data_ff.total_concealed <= total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (last_we) last_mem[mem_addr] <= req_data.sample_in;
   end

   always_ff @(posedge clock) begin
      if (hint_we) hint_mem[mem_addr] <= req_data.sample_in;
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         last_q_ff <= last_mem[mem_addr];
         hint_q_ff <= hint_mem[mem_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the weight-step wait");

   a_conceal_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.func == alc_pkg::FUNC_CONCEAL)) |=> (state_ff != S_IDLE))
      else $error("conceal request did not start the datapath");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WGT) |-> (step_ff <= alc_pkg::ONE_Q16))
      else $error("weight step above unity");

   a_frame_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.frame_end && (req_data.func != alc_pkg::FUNC_SKIP))
      |=> (pos_ff == '0))
      else $error("position not rewound after frame end");
`endif

endmodule

// ===== tb/tb_audio_loss_concealment_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for audio_loss_concealment_core: directed frames, long frames
// and random frame sequences under several register settings, checked beat by beat.
// Depends on alc_pkg and the core RTL; needs no files or arguments.

module tb_audio_loss_concealment_core;
   import alc_pkg::*;

   localparam int     DEPTH         = 480;
   localparam int     POS_LIMIT     = 511;
   localparam int     SETTLE_CYCLES = 40;
   localparam longint UNITY         = 65536;
   localparam longint SAMPLE_MAX    = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam logic [1:0] FUNC_IGNORED = 2'd3;
   localparam logic [1:0] STRAT_UNUSED = 2'd3;
   localparam logic [SAMPLE_W-1:0] PEAK_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] PEAK_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

   localparam logic [1:0] STRAT_PLAN [10] = '{STRAT_INTERP, STRAT_REPEAT, STRAT_SILENCE,
      STRAT_INTERP, STRAT_UNUSED, STRAT_REPEAT, STRAT_SILENCE, STRAT_INTERP, STRAT_REPEAT,
      STRAT_INTERP};
   localparam logic [3:0] CAP_PLAN [10] = '{4'd15, 4'd5, 4'd0, 4'd1, 4'd7, 4'd15, 4'd2,
      4'd3, 4'd0, 4'd10};

   class concealment_scoreboard;
      logic signed [SAMPLE_W-1:0] good_frame [DEPTH];
      logic signed [SAMPLE_W-1:0] hint_frame [DEPTH];
      int unsigned        last_len, hint_len, pos, step;
      bit                 have_last, have_hint;
      logic [3:0]         streak, cap;
      logic [1:0]         strategy, mode;
      logic [COUNT_W-1:0] concealed;
      rsp_type            expected_beats[$];
      int unsigned        mismatches, beats_checked, beats_produced;

      function new();
         foreach (good_frame[k]) begin
            good_frame[k] = '0;
            hint_frame[k] = '0;
         end
         strategy  = STRAT_REPEAT;
         cap       = 4'd5;
         streak    = '0;
         mode      = MODE_NONE;
         concealed = '0;
      endfunction

      function void set_config(logic [1:0] strat, logic [3:0] limit);
         strategy = strat;
         cap      = limit;
      endfunction

      // reads at or past the loaded length come back as silence
      function logic signed [SAMPLE_W-1:0] stored(bit from_hint, int unsigned i);
         if (from_hint) return (i < hint_len) ? hint_frame[i] : '0;
         return (i < last_len) ? good_frame[i] : '0;
      endfunction

      function logic signed [SAMPLE_W-1:0] crossfade(int unsigned i);
         longint weight, mix;
         weight = longint'(i) * longint'(step);
         if (weight > UNITY) weight = UNITY;
         mix = longint'(stored(1'b0, i)) * (UNITY - weight) + longint'(stored(1'b1, i)) * weight;
         mix = (mix + (UNITY >> 1)) >>> 16;
         if (mix > SAMPLE_MAX) mix = SAMPLE_MAX;
         if (mix < -SAMPLE_MAX - 1) mix = -SAMPLE_MAX - 1;
         return mix[SAMPLE_W-1:0];
      endfunction

      function void note_request(req_type r);
         int unsigned i, n, written;
         bit          hinted;
         rsp_type     e;
         i = pos;
         if (r.func == FUNC_IGNORED) return;
         if (r.func == FUNC_GOOD || r.func == FUNC_HINT) begin
            if (i == 0) mode = MODE_NONE;
            // drop samples past the store depth
            if (i < DEPTH) begin
               if (r.func == FUNC_GOOD) good_frame[i] = r.sample_in;
               else hint_frame[i] = r.sample_in;
            end
            if (r.frame_end) begin
               if (r.func == FUNC_GOOD) begin
                  last_len  = (i + 1 < DEPTH) ? i + 1 : DEPTH;
                  have_last = 1'b1;
                  streak    = '0;
               end else begin
                  hint_len  = (i + 1 < DEPTH) ? i + 1 : DEPTH;
                  have_hint = 1'b1;
               end
            end
         end else begin
            n       = (r.out_size < DEPTH) ? r.out_size : DEPTH;
            written = 0;
            e       = '0;
            if (i == 0) begin
               mode = MODE_NONE;
               if (streak < cap) begin
                  hinted    = have_hint;
                  have_hint = 1'b0;
                  case (strategy)
                     STRAT_SILENCE: mode = MODE_SILENCE;
                     STRAT_REPEAT: if (have_last) mode = MODE_REPEAT;
                     STRAT_INTERP: if (have_last) mode = hinted ? MODE_INTERP : MODE_REPEAT;
                     default: mode = MODE_NONE;
                  endcase
               end
               step = (n >= 2) ? (UNITY + (n - 1) / 2) / (n - 1) : 0;
            end
            case (mode)
               MODE_SILENCE: e.produced = (i < r.out_size);
               MODE_REPEAT: begin
                  e.produced = (i < n);
                  if (e.produced) e.out_sample = stored(1'b0, i);
               end
               MODE_INTERP: begin
                  e.produced = (i < n);
                  if (e.produced) e.out_sample = crossfade(i);
               end
               default: e.produced = 1'b0;
            endcase
            if (r.frame_end) begin
               if (mode == MODE_SILENCE) written = r.out_size;
               else if (mode == MODE_REPEAT || mode == MODE_INTERP) written = n;
               if (written > 0) begin
                  if (streak != 4'd15) streak++;
                  concealed++;
               end
            end
            e.out_last        = r.frame_end;
            e.written_count   = SIZE_W'(written);
            e.total_concealed = concealed;
            expected_beats.push_back(e);
         end
         if (r.frame_end) pos = 0;
         else if (pos < POS_LIMIT) pos++;
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("%0t: mismatch: %s", $time, what);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_beats.size() == 0) begin
            report($sformatf("response beat with nothing expected (sample %0d)", got.out_sample));
            return;
         end
         want = expected_beats.pop_front();
         beats_checked++;
         if (got.produced) beats_produced++;
         if (got.out_sample !== want.out_sample)
            report($sformatf("beat %0d out_sample %0d, want %0d", beats_checked,
                   got.out_sample, want.out_sample));
         if (got.produced !== want.produced)
            report($sformatf("beat %0d produced %b, want %b", beats_checked,
                   got.produced, want.produced));
         if (got.out_last !== want.out_last)
            report($sformatf("beat %0d out_last %b, want %b", beats_checked,
                   got.out_last, want.out_last));
         if (got.written_count !== want.written_count)
            report($sformatf("beat %0d written_count %0d, want %0d", beats_checked,
                   got.written_count, want.written_count));
         if (got.total_concealed !== want.total_concealed)
            report($sformatf("beat %0d total_concealed %0d, want %0d", beats_checked,
                   got.total_concealed, want.total_concealed));
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic                  csr_index = CSR_STRATEGY;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   concealment_scoreboard sb = new();

   int unsigned items_sent  = 0;
   int unsigned settings    = 0;
   int unsigned burst_left  = 0;
   bit          sender_calm = 1'b0;
   int unsigned stall_left  = 0;
   int unsigned stall_style = 0;
   int unsigned style_age   = 0;

   audio_loss_concealment_core #(.FRAME_DEPTH(DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // receiver: switch stall style every so often, including fully open stretches
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 16);
            end
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
      style_age++;
      if (style_age == 150) begin
         style_age   = 0;
         stall_style = $urandom_range(0, 3);
      end
   end

   task automatic send(logic [1:0] func, logic [SAMPLE_W-1:0] smp, logic fend,
                       logic [SIZE_W-1:0] osz);
      req_type     beat;
      int unsigned gap;
      beat.func      = func;
      beat.sample_in = smp;
      beat.frame_end = fend;
      beat.out_size  = osz;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_calm ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      sb.note_request(beat);
      if (func != FUNC_IGNORED) items_sent++;
   endtask

   // hold off until every response is back, then let the datapath settle
   task automatic drain_block();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(logic [1:0] strat, logic [3:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_STRATEGY;
      csr_wdata <= CSR_DATA_W'(strat);
      @(posedge clock);
      csr_index <= CSR_MAX_STREAK;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_config(strat, limit);
      settings++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return PEAK_POS;
         1: return PEAK_NEG;
         2: return '0;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_size(int unsigned count);
      case ($urandom_range(0, 4))
         0: return count;
         1: return count - 1;
         2: return $urandom_range(0, 3);
         3: return $urandom_range(0, DEPTH);
         default: return count + $urandom_range(0, 2);
      endcase
   endfunction

   task automatic sprinkle_noise();
      if ($urandom_range(0, 15) == 0)
         send(FUNC_IGNORED, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)), SIZE_W'($urandom));
   endtask

   task automatic load_frame(logic [1:0] func, int unsigned len);
      for (int k = 0; k < len; k++) begin
         sprinkle_noise();
         send(func, pick_sample(), k == len - 1, SIZE_W'($urandom));
      end
   endtask

   // broken frames slip load beats in between requests; the last beat stays a request
   task automatic conceal_frame(int unsigned count, int unsigned osz, bit broken);
      logic [1:0] kind;
      for (int k = 0; k < count; k++) begin
         kind = FUNC_CONCEAL;
         if (broken && k != count - 1 && $urandom_range(0, 3) == 0)
            kind = $urandom_range(0, 1) ? FUNC_HINT : FUNC_GOOD;
         sprinkle_noise();
         send(kind, (kind == FUNC_CONCEAL) ? SAMPLE_W'($urandom) : pick_sample(),
              k == count - 1, SIZE_W'(osz));
      end
   endtask

   task automatic random_phase(logic [1:0] strat, logic [3:0] limit, int unsigned quota);
      int unsigned start, count, run;
      drain_block();
      write_config(strat, limit);
      sender_calm = ($urandom_range(0, 3) == 0);
      start = items_sent;
      while (items_sent - start < quota) begin
         case ($urandom_range(0, 9))
            0, 1, 2: load_frame(FUNC_GOOD, ($urandom_range(0, 7) == 0) ?
                                $urandom_range(1, 40) : $urandom_range(1, 12));
            3, 4: load_frame(FUNC_HINT, ($urandom_range(0, 7) == 0) ?
                             $urandom_range(1, 40) : $urandom_range(1, 12));
            default: begin
               // runs of lost frames push the streak toward its cap
               run = $urandom_range(1, 6);
               repeat (run) begin
                  count = $urandom_range(1, 10);
                  conceal_frame(count, pick_size(count), $urandom_range(0, 6) == 0);
               end
            end
         endcase
         if ($urandom_range(0, 29) == 0) drain_block();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // nothing to repeat before the first good frame
      conceal_frame(2, 2, 1'b0);
      send(FUNC_GOOD, PEAK_POS, 1'b0, '0);
      send(FUNC_GOOD, PEAK_NEG, 1'b0, '1);
      send(FUNC_GOOD, SAMPLE_W'(1), 1'b1, '0);
      // repeat, last request past out_size is padding
      conceal_frame(4, 3, 1'b0);
      send(FUNC_HINT, PEAK_NEG, 1'b0, '0);
      send(FUNC_HINT, PEAK_POS, 1'b0, '0);
      send(FUNC_HINT, '1, 1'b1, '0);
      send(FUNC_IGNORED, '1, 1'b1, '1);
      drain_block();
      write_config(STRAT_INTERP, 4'd15);
      conceal_frame(3, 3, 1'b0);
      // hint consumed: falls back to repeat, single-sample frame
      conceal_frame(1, 1, 1'b0);
      drain_block();
      write_config(STRAT_SILENCE, 4'd15);
      conceal_frame(2, 0, 1'b0);
      conceal_frame(2, 1, 1'b0);

      // overlong good frame: drop past the store depth, position saturates
      drain_block();
      write_config(STRAT_REPEAT, 4'd15);
      load_frame(FUNC_GOOD, POS_LIMIT + 2);
      conceal_frame(6, DEPTH, 1'b0);
      load_frame(FUNC_HINT, 8);
      drain_block();
      write_config(STRAT_INTERP, 4'd15);
      conceal_frame(5, DEPTH, 1'b0);

      for (int p = 0; p < 10; p++) random_phase(STRAT_PLAN[p], CAP_PLAN[p], 85);

      drain_block();
      $display("Covered %0d request beats across %0d register settings; %0d responses checked,",
               items_sent, settings, sb.beats_checked);
      $display("%0d of them produced, concealed frame count ended at %0d, %0d mismatches.",
               sb.beats_produced, sb.concealed, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Timeout with %0d responses outstanding", sb.expected_beats.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== audio_loss_concealment_core.f =====
hw/rtl/alc_pkg.sv
hw/rtl/alc_div.sv
hw/rtl/audio_loss_concealment_core.sv
tb/tb_audio_loss_concealment_core.sv
